### src/tofm_pkg.sv
// tofm_pkg: shared types and constants for the time-of-flight to mass calibration block
// used by tofm_unit and tof_to_mass_calibration; no dependencies
package tofm_pkg;

	localparam int unsigned FRAC_W  = 24;  // Q.24 fraction bits
	localparam int unsigned WORD_W  = 56;  // signed Q32.24 register width
	localparam int unsigned BCOEF_W = 55;
	localparam int unsigned LEVEL_W = 32;
	localparam int unsigned CFG_IDX_W = 3;

	// shared unit sizing
	localparam int unsigned MUL_W  = 57;   // multiplier operand bits
	localparam int unsigned RAD_W  = 116;  // radicand / accumulator bits
	localparam int unsigned ROOT_W = 58;   // square root bits
	localparam int unsigned NUM_W  = 82;   // dividend bits
	localparam int unsigned DEN_W  = 57;   // divisor bits
	localparam int unsigned REM_W  = 61;   // partial remainder bits
	localparam int unsigned CNT_W  = 7;
	localparam int unsigned Q_LIM  = 40;   // quotient must stay below 2^40

	localparam logic [CFG_IDX_W-1:0] REG_DELAY  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DWELL  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BCOEF  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LINEAR = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_QUAD   = 3'd4;

	typedef enum logic [1:0] {
		OP_MUL  = 2'd0,
		OP_DIV  = 2'd1,
		OP_SQRT = 2'd2
	} unit_op_t;

	typedef struct packed {
		logic     start;
		unit_op_t op;
	} unit_req_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] intensity;
		logic               final_sample;
	} item_t;

	typedef struct packed {
		logic [WORD_W-1:0]  mass;
		logic [LEVEL_W-1:0] level;
		logic               is_last;
		logic               invalid;
	} result_t;

endpackage

### src/tofm_unit.sv
// tofm_unit: bit-serial multiply, restoring divide and digit-by-digit square root
// one bit (or bit pair) per cycle; depends on tofm_pkg
module tofm_unit (
	input  logic                     clk,
	input  logic                     arst_n,
	input  tofm_pkg::unit_req_t      req,
	input  logic [tofm_pkg::RAD_W-1:0] a,
	input  logic [tofm_pkg::DEN_W-1:0] b,
	output logic [tofm_pkg::RAD_W-1:0] res,
	output logic                     done
);

	localparam int unsigned RW = tofm_pkg::RAD_W;
	localparam int unsigned EW = tofm_pkg::REM_W;

	tofm_pkg::unit_op_t op_q;
	logic                        busy_q;
	logic                        done_q;
	logic [tofm_pkg::CNT_W-1:0]  cnt_q;
	logic [tofm_pkg::CNT_W-1:0]  last_cnt;
	logic [RW-1:0]               x_q;
	logic [RW-1:0]               acc_q;
	logic [tofm_pkg::DEN_W-1:0]  y_q;
	logic [EW-1:0]               rem_q;

	logic [EW-1:0] r2;
	logic [EW-1:0] sub_b;
	logic [EW-1:0] diff;
	logic          take;
	logic [RW-1:0] sum;

	always_comb begin
		case (op_q)
			tofm_pkg::OP_MUL:  last_cnt = tofm_pkg::CNT_W'(tofm_pkg::MUL_W - 1);
			tofm_pkg::OP_DIV:  last_cnt = tofm_pkg::CNT_W'(tofm_pkg::NUM_W - 1);
			tofm_pkg::OP_SQRT: last_cnt = tofm_pkg::CNT_W'(tofm_pkg::ROOT_W - 1);
			default:           last_cnt = '0;
		endcase
	end

	// one compare and subtract shared by divide and square root
	always_comb begin
		if (op_q == tofm_pkg::OP_DIV) begin
			r2    = {rem_q[EW-2:0], x_q[RW-1]};
			sub_b = EW'(y_q);
		end else begin
			r2    = {rem_q[EW-3:0], x_q[RW-1 -: 2]};
			sub_b = {acc_q[EW-3:0], 2'b01};
		end
		diff = r2 - sub_b;
		take = (r2 >= sub_b);
		sum  = acc_q + x_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			op_q   <= tofm_pkg::OP_MUL;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				op_q   <= req.op;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == last_cnt) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q <= '0;
			rem_q <= '0;
			y_q   <= b;
			if (req.op == tofm_pkg::OP_DIV) begin
				// dividend left aligned so its top bit enters first
				x_q <= a << (RW - tofm_pkg::NUM_W);
			end else begin
				x_q <= a;
			end
		end else if (busy_q) begin
			case (op_q)
				tofm_pkg::OP_MUL: begin
					if (y_q[0]) begin
						acc_q <= sum;
					end
					x_q <= x_q << 1;
					y_q <= y_q >> 1;
				end
				tofm_pkg::OP_DIV: begin
					rem_q <= take ? diff : r2;
					acc_q <= {acc_q[RW-2:0], take};
					x_q   <= x_q << 1;
				end
				tofm_pkg::OP_SQRT: begin
					rem_q <= take ? diff : r2;
					acc_q <= {acc_q[RW-2:0], take};
					x_q   <= x_q << 2;
				end
				default: begin
					acc_q <= acc_q;
				end
			endcase
		end
	end

	assign res  = acc_q;
	assign done = done_q;

endmodule

### src/tof_to_mass_calibration.sv
// tof_to_mass_calibration: top level, sequencer, registers and sample index
// depends on tofm_pkg and tofm_unit
//
// One sample is taken at a time and the block is not ready until its result has been
// formed. The time product, B squared, 4AC, the square root, the division and the final
// square all run on one bit-serial unit, one bit per cycle. A sample with a zero quadratic
// coefficient skips B squared, 4AC and the square root, and one flagged invalid early in
// the chain finishes sooner. A finished result waits in an output register, so the next
// sample is taken while it is still unread.
module tof_to_mass_calibration #(
	parameter int unsigned INDEX_BITS = 24
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              item_valid,
	output logic                              item_ready,
	input  tofm_pkg::item_t                   item,
	output logic                              result_valid,
	input  logic                              result_ready,
	output tofm_pkg::result_t                 result,
	input  logic                              wr_en,
	input  logic [tofm_pkg::CFG_IDX_W-1:0]    wr_index,
	input  logic [tofm_pkg::WORD_W-1:0]       wr_data
);

	localparam int unsigned W  = tofm_pkg::WORD_W;
	localparam int unsigned RW = tofm_pkg::RAD_W;
	localparam int unsigned FW = tofm_pkg::FRAC_W;

	typedef enum logic [10:0] {
		S_IDLE  = 11'b00000000001,
		S_TMUL  = 11'b00000000010,
		S_TIME  = 11'b00000000100,
		S_COEF  = 11'b00000001000,
		S_FORM  = 11'b00000010000,
		S_B2    = 11'b00000100000,
		S_AC    = 11'b00001000000,
		S_DISC  = 11'b00010000000,
		S_SQRT  = 11'b00100000000,
		S_DIV   = 11'b01000000000,
		S_SQR   = 11'b10000000000
	} state_t;

	// S_DIV also covers the quotient check and S_SQR the hand-off, see below
	state_t state_q;
	logic   qchk_q;   // quotient ready, check and square
	logic   fin_q;    // result formed, waiting for the output register

	logic [W-1:0]                 delay_q, dwell_q, ml2_q, quad_q;
	logic [tofm_pkg::BCOEF_W-1:0] b_q;
	logic [INDEX_BITS-1:0]        sample_index_q;

	logic [tofm_pkg::LEVEL_W-1:0] level_q;
	logic                         last_q;
	logic                         bad_q;
	logic [W-1:0]                 t_q;
	logic [tofm_pkg::MUL_W-1:0]   cm_q;
	logic                         cneg_q;
	logic [109:0]                 b2_q;
	logic [W-1:0]                 mass_q;

	logic                         out_valid_q;
	tofm_pkg::result_t            out_q;

	tofm_pkg::unit_req_t          ureq;
	logic [RW-1:0]                ua;
	logic [tofm_pkg::DEN_W-1:0]   ub;
	logic [RW-1:0]                ures;
	logic                         udone;

	logic                         accept;
	logic                         load_out;
	logic [W-1:0]                 dwell_mag, quad_mag;
	logic                         prod_big;
	logic [59:0]                  t60;
	logic                         t_ok;
	logic [57:0]                  c58, cm58;
	logic [RW-1:0]                ac, b2w, disc;
	logic                         b2_ge;
	logic [tofm_pkg::ROOT_W-1:0]  root, bw, nm;
	logic                         q_big;

	tofm_unit u_unit (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (ureq),
		.a      (ua),
		.b      (ub),
		.res    (ures),
		.done   (udone)
	);

	assign item_ready = (state_q == S_IDLE) && !qchk_q && !fin_q;
	assign accept     = item_valid && item_ready;
	assign load_out   = fin_q && (!out_valid_q || result_ready);

	always_comb begin
		dwell_mag = dwell_q[W-1] ? W'(-dwell_q) : dwell_q;
		quad_mag  = quad_q[W-1] ? W'(-quad_q) : quad_q;

		prod_big = (|ures[RW-1:58]) || (ures[57] && (|ures[56:0]));
		if (dwell_q[W-1]) begin
			t60 = {{4{delay_q[W-1]}}, delay_q} - {2'b00, ures[57:0]};
		end else begin
			t60 = {{4{delay_q[W-1]}}, delay_q} + {2'b00, ures[57:0]};
		end
		t_ok = (t60[59:55] == 5'b00000) || (t60[59:55] == 5'b11111);

		c58  = {{2{ml2_q[W-1]}}, ml2_q} - {{2{t_q[W-1]}}, t_q};
		cm58 = c58[57] ? 58'(-c58) : c58;

		ac    = {ures[RW-3:0], 2'b00};
		b2w   = RW'(b2_q);
		b2_ge = (b2w >= ac);
		disc  = ((quad_q[W-1] == cneg_q)) ? (b2w - ac) : (b2w + ac);

		root = ures[tofm_pkg::ROOT_W-1:0];
		bw   = tofm_pkg::ROOT_W'(b_q);
		nm   = (root >= bw) ? (root - bw) : (bw - root);

		q_big = |ures[tofm_pkg::NUM_W-1:tofm_pkg::Q_LIM];
	end

	// start requests to the shared unit
	always_comb begin
		ureq.start = 1'b0;
		ureq.op    = tofm_pkg::OP_MUL;
		ua         = '0;
		ub         = '0;
		if (accept) begin
			ureq.start = 1'b1;
			ua         = RW'(sample_index_q);
			ub         = tofm_pkg::DEN_W'(dwell_mag);
		end else begin
			case (state_q)
				S_FORM: begin
					if (quad_q == '0) begin
						if (b_q != '0) begin
							ureq.start = 1'b1;
							ureq.op    = tofm_pkg::OP_DIV;
							ua         = RW'({cm_q, {FW{1'b0}}});
							ub         = tofm_pkg::DEN_W'(b_q);
						end
					end else begin
						ureq.start = 1'b1;
						ua         = RW'(b_q);
						ub         = tofm_pkg::DEN_W'(b_q);
					end
				end
				S_B2: begin
					if (udone) begin
						ureq.start = 1'b1;
						ua         = RW'(quad_mag);
						ub         = cm_q;
					end
				end
				S_DISC: begin
					if ((quad_q[W-1] != cneg_q) || b2_ge) begin
						ureq.start = 1'b1;
						ureq.op    = tofm_pkg::OP_SQRT;
						ua         = disc;
					end
				end
				S_SQRT: begin
					if (udone) begin
						ureq.start = 1'b1;
						ureq.op    = tofm_pkg::OP_DIV;
						ua         = RW'({nm, {FW{1'b0}}});
						ub         = {quad_mag, 1'b0};
					end
				end
				S_DIV: begin
					if (qchk_q && !q_big) begin
						ureq.start = 1'b1;
						ua         = RW'(ures[tofm_pkg::Q_LIM-1:0]);
						ub         = tofm_pkg::DEN_W'(ures[tofm_pkg::Q_LIM-1:0]);
					end
				end
				default: begin
					ureq.start = 1'b0;
				end
			endcase
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q <= '0;
			dwell_q <= '0;
			b_q     <= tofm_pkg::BCOEF_W'(1) << FW;
			ml2_q   <= '0;
			quad_q  <= '0;
		end else if (wr_en) begin
			case (wr_index)
				tofm_pkg::REG_DELAY:  delay_q <= wr_data;
				tofm_pkg::REG_DWELL:  dwell_q <= wr_data;
				tofm_pkg::REG_BCOEF:  b_q     <= wr_data[tofm_pkg::BCOEF_W-1:0];
				tofm_pkg::REG_LINEAR: ml2_q   <= wr_data;
				tofm_pkg::REG_QUAD:   quad_q  <= wr_data;
				default: begin
					delay_q <= delay_q;
				end
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			qchk_q         <= 1'b0;
			fin_q          <= 1'b0;
			sample_index_q <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
				fin_q       <= 1'b0;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end

			if (accept) begin
				sample_index_q <= item.final_sample ? '0 : sample_index_q + 1'b1;
				state_q        <= S_TMUL;
			end

			case (state_q)
				S_TMUL: begin
					if (udone) begin
						state_q <= prod_big ? S_IDLE : S_TIME;
						fin_q   <= prod_big;
					end
				end
				S_TIME: begin
					state_q <= t_ok ? S_COEF : S_IDLE;
					fin_q   <= !t_ok;
				end
				S_COEF: state_q <= S_FORM;
				S_FORM: begin
					if (quad_q == '0) begin
						state_q <= (b_q != '0) ? S_DIV : S_IDLE;
						fin_q   <= (b_q == '0);
					end else begin
						state_q <= S_B2;
					end
				end
				S_B2:   if (udone) state_q <= S_AC;
				S_AC:   if (udone) state_q <= S_DISC;
				S_DISC: begin
					if ((quad_q[W-1] != cneg_q) || b2_ge) begin
						state_q <= S_SQRT;
					end else begin
						state_q <= S_IDLE;
						fin_q   <= 1'b1;
					end
				end
				S_SQRT: if (udone) state_q <= S_DIV;
				S_DIV: begin
					if (qchk_q) begin
						qchk_q  <= 1'b0;
						state_q <= q_big ? S_IDLE : S_SQR;
						fin_q   <= q_big;
					end else if (udone) begin
						qchk_q <= 1'b1;
					end
				end
				S_SQR: begin
					if (udone) begin
						state_q <= S_IDLE;
						fin_q   <= 1'b1;
					end
				end
				default: begin
					qchk_q <= qchk_q;
				end
			endcase
		end
	end

	// sample payload and intermediate values
	always_ff @(posedge clk) begin
		if (accept) begin
			level_q <= item.intensity;
			last_q  <= item.final_sample;
			bad_q   <= 1'b0;
		end
		case (state_q)
			S_TMUL: if (udone && prod_big) bad_q <= 1'b1;
			S_TIME: begin
				t_q <= t60[W-1:0];
				if (!t_ok) bad_q <= 1'b1;
			end
			S_COEF: begin
				cm_q   <= cm58[tofm_pkg::MUL_W-1:0];
				cneg_q <= c58[57];
			end
			S_FORM: if ((quad_q == '0) && (b_q == '0)) bad_q <= 1'b1;
			S_B2:   if (udone) b2_q <= ures[109:0];
			S_DISC: if ((quad_q[W-1] == cneg_q) && !b2_ge) bad_q <= 1'b1;
			S_DIV:  if (qchk_q && q_big) bad_q <= 1'b1;
			S_SQR:  if (udone) mass_q <= ures[W+FW-1:FW];
			default: begin
				mass_q <= mass_q;
			end
		endcase
		if (load_out) begin
			out_q.mass    <= bad_q ? {W{1'b1}} : mass_q;
			out_q.level   <= level_q;
			out_q.is_last <= last_q;
			out_q.invalid <= bad_q;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

	// checks
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !item_ready)
		else $error("ready while a request is in progress");

	a_index_restart: assert property (@(posedge clk) disable iff (!arst_n)
		accept && item.final_sample |=> sample_index_q == '0)
		else $error("sample index not restarted after final sample");

	a_saturate: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.invalid |-> result.mass == {W{1'b1}})
		else $error("invalid result not saturated");

	a_unit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		item_ready |-> !udone)
		else $error("unit finished with no request in progress");

endmodule

### dv/tof_to_mass_calibration_test.sv
// tof_to_mass_calibration_test: self-checking bench for the tof to mass calibration block
// needs tofm_pkg and tof_to_mass_calibration; a directed table, then random spectra
// checked against a local model of the fixed-point calibration
`timescale 1ns / 1ps

module tof_to_mass_calibration_test;

	localparam logic [55:0] ONE_Q = 56'd1 << 24;
	localparam logic [55:0] MAX_S = 56'h7F_FFFF_FFFF_FFFF;
	localparam logic [55:0] MIN_S = 56'h80_0000_0000_0000;
	localparam logic [55:0] ALL_1 = 56'hFF_FFFF_FFFF_FFFF;
	localparam int unsigned N_RAND_PHASES = 10;
	localparam int unsigned PHASE_ITEMS = 85;
	localparam int unsigned HOLD_CYCLES = 3000;
	localparam int unsigned END_WAIT = 500;
	localparam longint unsigned CYCLE_LIMIT = 3000000;

	typedef struct packed {
		logic              load;
		logic [4:0][55:0]  regs;
		logic [31:0]       intensity;
		logic              final_sample;
		logic              typed;
		logic [55:0]       mass;
		logic              invalid;
	} vec_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_ready;
	tofm_pkg::item_t item = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	tofm_pkg::result_t result;
	logic wr_en = 1'b0;
	logic [tofm_pkg::CFG_IDX_W-1:0] wr_index = tofm_pkg::REG_DELAY;
	logic [tofm_pkg::WORD_W-1:0] wr_data = '0;

	// shadow of the block's registers and sample counter
	logic signed [55:0] delay_r, dwell_r, linear_r, quad_r;
	logic [54:0] bcoef_r;
	logic [23:0] index_r;

	tofm_pkg::result_t mass_q[$];
	vec_t vec_tbl[$];
	int unsigned fails = 0, n_sent = 0, n_checked = 0, n_invalid = 0;
	longint unsigned cycles = 0;
	logic calm = 1'b0;
	logic hold_req = 1'b0;
	int unsigned hold_left = 0;

	tof_to_mass_calibration uut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_ready(item_ready), .item(item),
		.result_valid(result_valid), .result_ready(result_ready), .result(result),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic logic [63:0] root_floor(input logic [127:0] x);
		logic [127:0] res, cand;
		res = '0;
		for (int i = 63; i >= 0; i--) begin
			cand = res | (128'd1 << i);
			if (cand * cand <= x)
				res = cand;
		end
		return res[63:0];
	endfunction

	// calibrated mass for one sample, advances the sample counter
	function automatic tofm_pkg::result_t calibrate(input tofm_pkg::item_t it);
		tofm_pkg::result_t r;
		logic bad;
		longint dl, dw, ln, qa, t, c;
		logic [63:0] dm, cm, am, s, nm, p;
		logic [127:0] prod, qv, b2, ac, disc, num, den, sq;
		bad = 1'b0;
		qv = '0;
		dl = delay_r; dw = dwell_r; ln = linear_r; qa = quad_r;
		dm = dw < 0 ? -dw : dw;
		prod = {104'd0, index_r};
		prod = prod * {64'd0, dm};
		if (prod > (128'd1 << 57)) begin
			bad = 1'b1;
		end else begin
			p = prod[63:0];
			t = dl + (dw < 0 ? -longint'(p) : longint'(p));
			if (t < -(longint'(1) << 55) || t > (longint'(1) << 55) - 1) begin
				bad = 1'b1;
			end else begin
				c = ln - t;
				cm = c < 0 ? -c : c;
				if (qa == 0) begin
					if (bcoef_r == 0) begin
						bad = 1'b1;
					end else begin
						num = {64'd0, cm} << 24;
						qv = num / {73'd0, bcoef_r};
					end
				end else begin
					am = qa < 0 ? -qa : qa;
					b2 = {73'd0, bcoef_r};
					b2 = b2 * {73'd0, bcoef_r};
					ac = {64'd0, am};
					ac = (ac * {64'd0, cm}) << 2;
					if ((qa < 0) == (c < 0)) begin
						if (b2 >= ac) disc = b2 - ac;
						else bad = 1'b1;
					end else begin
						disc = b2 + ac;
					end
					if (!bad) begin
						s = root_floor(disc);
						nm = s >= bcoef_r ? s - bcoef_r : bcoef_r - s;
						num = {64'd0, nm} << 24;
						den = {64'd0, am} << 1;
						qv = num / den;
					end
				end
			end
		end
		// mass overflow once the quotient reaches 2^40
		if (!bad && qv >= (128'd1 << 40))
			bad = 1'b1;
		sq = qv * qv;
		r.mass = bad ? ALL_1 : sq[79:24];
		r.level = it.intensity;
		r.is_last = it.final_sample;
		r.invalid = bad;
		index_r = it.final_sample ? 24'd0 : index_r + 24'd1;
		return r;
	endfunction

	task automatic wait_drained();
		while (mass_q.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_regs(input logic [4:0][55:0] v);
		wait_drained();
		for (int i = 0; i < 5; i++) begin
			wr_en <= 1'b1;
			wr_index <= tofm_pkg::CFG_IDX_W'(i);
			wr_data <= v[i];
			@(posedge clk);
		end
		wr_en <= 1'b0;
		delay_r = v[tofm_pkg::REG_DELAY];
		dwell_r = v[tofm_pkg::REG_DWELL];
		bcoef_r = v[tofm_pkg::REG_BCOEF][54:0];
		linear_r = v[tofm_pkg::REG_LINEAR];
		quad_r = v[tofm_pkg::REG_QUAD];
	endtask

	task automatic send(input tofm_pkg::item_t it, input logic typed, input logic [55:0] tm,
			input logic ti);
		tofm_pkg::result_t e;
		if (!calm && $urandom_range(99) < 13) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		do @(posedge clk); while (!item_ready);
		e = calibrate(it);
		if (typed) begin
			e.mass = tm;
			e.invalid = ti;
		end
		mass_q.push_back(e);
		n_sent++;
	endtask

	task automatic add_row(input logic load, input logic [55:0] d, dw, b, l, a,
			input logic [31:0] inten, input logic fin, input logic typed,
			input logic [55:0] m, input logic inv);
		vec_t v;
		v.load = load;
		v.regs = {a, l, b, dw, d};
		v.intensity = inten;
		v.final_sample = fin;
		v.typed = typed;
		v.mass = m;
		v.invalid = inv;
		vec_tbl.push_back(v);
	endtask

	function automatic logic [55:0] small_signed(input int unsigned range);
		longint v;
		v = longint'($urandom_range(0, 2 * range)) - longint'(range);
		return v[55:0];
	endfunction

	function automatic logic [55:0] wide_rand();
		return {$urandom, $urandom} & ALL_1;
	endfunction

	// result side: random stalls, a long hold-off on request
	always @(posedge clk) begin
		if (hold_req) begin
			hold_left <= HOLD_CYCLES;
			result_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			result_ready <= hold_left == 1;
		end else begin
			result_ready <= calm || $urandom_range(99) >= 13;
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			if (mass_q.size() == 0) begin
				$error("result with no request outstanding: mass %h", result.mass);
				fails++;
			end else begin
				tofm_pkg::result_t e;
				e = mass_q.pop_front();
				n_checked++;
				if (e.invalid) n_invalid++;
				if (result.mass !== e.mass) begin
					$error("mass expected %h actual %h", e.mass, result.mass);
					fails++;
				end
				if (result.level !== e.level) begin
					$error("level expected %h actual %h", e.level, result.level);
					fails++;
				end
				if (result.is_last !== e.is_last) begin
					$error("is_last expected %b actual %b", e.is_last, result.is_last);
					fails++;
				end
				if (result.invalid !== e.invalid) begin
					$error("invalid expected %b actual %b", e.invalid, result.invalid);
					fails++;
				end
			end
		end
	end

	initial begin
		logic [4:0][55:0] cfg;
		tofm_pkg::item_t it;
		delay_r = '0; dwell_r = '0; bcoef_r = ONE_Q[54:0]; linear_r = '0; quad_r = '0;
		index_r = '0;

		// defaults give c = 0, so zero mass
		add_row(0, 0, 0, ONE_Q, 0, 0, 32'h0, 0, 1, 56'd0, 0);
		add_row(0, 0, 0, ONE_Q, 0, 0, 32'hFFFF_FFFF, 1, 1, 56'd0, 0);
		// c = 2.0 over b = 1.0 squared gives 4.0
		add_row(1, 0, 0, ONE_Q, 2 * ONE_Q, 0, 32'h1234_5678, 1, 1, 4 * ONE_Q, 0);
		// zero divisor in the pure form
		add_row(1, 0, 0, 0, 2 * ONE_Q, 0, 32'h8000_0001, 1, 1, ALL_1, 1);
		// general form, c = 0: root equals b, zero mass
		add_row(1, 0, 0, ONE_Q, 0, ONE_Q, 32'h5555_5555, 1, 1, 56'd0, 0);
		// negative discriminant
		add_row(1, 0, 0, ONE_Q, ONE_Q, ONE_Q, 32'hAAAA_AAAA, 1, 1, ALL_1, 1);
		add_row(1, 0, 0, ONE_Q, ONE_Q, -ONE_Q, 32'h0000_FFFF, 1, 0, 0, 0);
		add_row(1, 0, 0, 3 * ONE_Q, -5 * ONE_Q, ONE_Q / 2, 32'hFFFF_0000, 1, 0, 0, 0);
		// flight time leaves the 56-bit range on the second sample
		add_row(1, MAX_S, MAX_S, ONE_Q, 0, 0, 32'h1, 0, 0, 0, 0);
		add_row(0, MAX_S, MAX_S, ONE_Q, 0, 0, 32'h2, 0, 1, ALL_1, 1);
		add_row(0, MAX_S, MAX_S, ONE_Q, 0, 0, 32'h3, 0, 0, 0, 0);
		add_row(0, MAX_S, MAX_S, ONE_Q, 0, 0, 32'h4, 0, 0, 0, 0);
		add_row(0, MAX_S, MAX_S, ONE_Q, 0, 0, 32'h5, 0, 0, 0, 0);
		// index times dwell beyond 2^57
		add_row(0, MAX_S, MAX_S, ONE_Q, 0, 0, 32'h6, 1, 1, ALL_1, 1);
		// mass overflow with a tiny b
		add_row(1, 0, 0, 56'd1, MAX_S, 0, 32'h7, 1, 1, ALL_1, 1);
		// register extremes
		add_row(1, MIN_S, MIN_S, {1'b0, {55{1'b1}}}, MIN_S, MIN_S, 32'h8, 0, 0, 0, 0);
		add_row(0, MIN_S, MIN_S, {1'b0, {55{1'b1}}}, MIN_S, MIN_S, 32'h9, 1, 0, 0, 0);
		add_row(1, MIN_S, 56'd1, {1'b0, {55{1'b1}}}, MAX_S, MAX_S, 32'hA, 0, 0, 0, 0);
		add_row(0, MIN_S, 56'd1, {1'b0, {55{1'b1}}}, MAX_S, MAX_S, 32'hB, 1, 0, 0, 0);
		add_row(1, ONE_Q, -ONE_Q / 4, ONE_Q / 3, 7 * ONE_Q, -ONE_Q, 32'hC, 0, 0, 0, 0);
		add_row(0, ONE_Q, -ONE_Q / 4, ONE_Q / 3, 7 * ONE_Q, -ONE_Q, 32'hD, 0, 0, 0, 0);
		add_row(0, ONE_Q, -ONE_Q / 4, ONE_Q / 3, 7 * ONE_Q, -ONE_Q, 32'hE, 1, 0, 0, 0);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (vec_tbl[i]) begin
			if (vec_tbl[i].load) begin
				// nothing offered while the registers change
				item_valid <= 1'b0;
				write_regs(vec_tbl[i].regs);
			end
			it.intensity = vec_tbl[i].intensity;
			it.final_sample = vec_tbl[i].final_sample;
			send(it, vec_tbl[i].typed, vec_tbl[i].mass, vec_tbl[i].invalid);
		end
		item_valid <= 1'b0;

		for (int ph = 0; ph < N_RAND_PHASES; ph++) begin
			if (ph % 4 == 3) begin
				cfg = {wide_rand(), wide_rand(), wide_rand() >> 1, wide_rand(), wide_rand()};
			end else begin
				cfg[tofm_pkg::REG_DELAY] = small_signed(1 << 30);
				cfg[tofm_pkg::REG_DWELL] = small_signed(1 << 20);
				cfg[tofm_pkg::REG_BCOEF] = 56'($urandom_range(1 << 20, 1 << 30));
				cfg[tofm_pkg::REG_LINEAR] = small_signed(32'h7FFF_FFFF);
				cfg[tofm_pkg::REG_QUAD] = $urandom_range(2) == 0 ? 56'd0 : small_signed(1 << 22);
			end
			write_regs(cfg);
			calm <= ph == 2;
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if (ph == 5 && k == 10) begin
					item_valid <= 1'b0;
					hold_req <= 1'b1;
					@(posedge clk);
					hold_req <= 1'b0;
				end
				// let the pipeline drain fully before carrying on
				if (ph == 6 && k == 40) begin
					item_valid <= 1'b0;
					wait_drained();
				end
				it.intensity = $urandom;
				it.final_sample = $urandom_range(19) == 0;
				send(it, 1'b0, '0, 1'b0);
			end
			item_valid <= 1'b0;
		end

		calm <= 1'b0;
		while (mass_q.size() != 0)
			@(posedge clk);
		repeat (END_WAIT) @(posedge clk);
		$display("%0d samples sent, %0d results checked (%0d flagged invalid)",
			n_sent, n_checked, n_invalid);
		$display("covered pure and general forms, time and mass overflow, zero b, stalls");
		if (fails == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

### files.f
src/tofm_pkg.sv
src/tofm_unit.sv
src/tof_to_mass_calibration.sv
dv/tof_to_mass_calibration_test.sv
